// ===== hdl/ptd_pkg.sv =====
// Package for the phase-angle triac dimmer core: widths, reset values,
// register indexes and the item record passed between the delay pipe and the phase unit.
`timescale 1ns / 1ps

package ptd_pkg;

    localparam int HALF_W  = 16;
    localparam int PULSE_W = 12;
    localparam int DEB_W   = 16;
    localparam int PCT_W   = 8;
    localparam int TICK_W  = 32;
    localparam int CFG_W   = 16;

    localparam logic [PCT_W-1:0] PCT_FULL = 8'd100;

    // Exact floor(x/100) for x < 2^23: (x * RECIP_100) >> RECIP_SHIFT
    localparam int PROD_W      = 23;
    localparam int RECIP_W     = 24;
    localparam int RECIP_SHIFT = 30;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;

    localparam logic [HALF_W-1:0]  HALF_RST  = 16'd10000;
    localparam logic [PULSE_W-1:0] PULSE_RST = 12'd100;
    localparam logic [DEB_W-1:0]   DEB_RST   = 16'd2000;

    typedef enum logic [1:0] {
        CFG_HALF_CYCLE  = 2'd0,
        CFG_GATE_PULSE  = 2'd1,
        CFG_ZC_DEBOUNCE = 2'd2
    } cfg_idx_t;

    // One tick request after the delay pipe
    typedef struct packed {
        logic              rise;
        logic              pct_zero;
        logic              pct_full;
        logic [HALF_W-1:0] delay;
    } ptd_item_t;

endpackage

// ===== hdl/ptd_delay.sv =====
// Three-stage pipe: input register, half_cycle*(100-p) product, divide by 100 and clamp.
// Depends on ptd_pkg.
`timescale 1ns / 1ps

module ptd_delay (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       rise,
    input  logic [ptd_pkg::PCT_W-1:0]  pct,
    input  logic [ptd_pkg::HALF_W-1:0] half_cycle,
    input  logic [ptd_pkg::HALF_W-1:0] delay_limit,
    output logic                       item_valid,
    input  logic                       item_ready,
    output ptd_pkg::ptd_item_t         item
);
    import ptd_pkg::*;

    localparam int MUL_W = PROD_W + RECIP_W;

    logic                v1_reg, v2_reg, v3_reg;
    logic                rdy1, rdy2, rdy3;
    logic                rise1_reg;
    logic [PCT_W-1:0]    pct1_reg;
    logic                rise2_reg, zero2_reg, full2_reg;
    logic [PROD_W-1:0]   prod2_reg;
    ptd_item_t           item3_reg;

    logic [6:0]          comp;
    logic [PROD_W-1:0]   prod_next;
    logic [MUL_W-1:0]    recip_mul;
    logic [HALF_W-1:0]   quot;
    ptd_item_t           item3_next;

    assign rdy3     = !v3_reg || item_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // stage 2: product
    assign comp      = 7'(PCT_FULL - pct1_reg);
    assign prod_next = {7'd0, half_cycle} * {16'd0, comp};

    // stage 3: reciprocal divide, then clamp
    assign recip_mul = MUL_W'(prod2_reg) * MUL_W'(RECIP_100);
    assign quot      = recip_mul[RECIP_SHIFT+HALF_W-1:RECIP_SHIFT];

    always_comb
    begin
        item3_next.rise     = rise2_reg;
        item3_next.pct_zero = zero2_reg;
        item3_next.pct_full = full2_reg;
        item3_next.delay    = (quot > delay_limit) ? delay_limit : quot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
            if (rdy3)
                v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
        begin
            rise1_reg <= rise;
            pct1_reg  <= pct;
        end
        if (rdy2 && v1_reg)
        begin
            rise2_reg <= rise1_reg;
            zero2_reg <= (pct1_reg == '0);
            full2_reg <= (pct1_reg >= PCT_FULL);
            prod2_reg <= prod_next;
        end
        if (rdy3 && v2_reg)
            item3_reg <= item3_next;
    end

    assign item_valid = v3_reg;
    assign item       = item3_reg;

endmodule

// ===== hdl/ptd_phase.sv =====
// Tick state: debounce, one-shot alarm, gate pulse counter and the result register.
// Depends on ptd_pkg.
`timescale 1ns / 1ps

module ptd_phase (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        item_valid,
    output logic                        item_ready,
    input  ptd_pkg::ptd_item_t          item,
    input  logic [ptd_pkg::PULSE_W-1:0] gate_pulse,
    input  logic [ptd_pkg::DEB_W-1:0]   zc_debounce,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        gate_level,
    output logic                        zc_accepted
);
    import ptd_pkg::*;

    logic [TICK_W-1:0]   tick_count_reg, last_cross_reg, fire_time_reg;
    logic [TICK_W-1:0]   last_cross_next, fire_time_next, since_cross;
    logic                armed_reg, armed_next, armed_mid;
    logic [PULSE_W-1:0]  pulse_reg, pulse_next, pulse_mid;
    logic                accepted, hit, gate;
    logic                out_valid_reg, gate_level_reg, zc_accepted_reg;
    logic                load;

    assign item_ready = !out_valid_reg || !out_stall;
    assign load       = item_valid && item_ready;

    assign since_cross = tick_count_reg - last_cross_reg;

    always_comb
    begin
        accepted        = item.rise && (since_cross >= TICK_W'(zc_debounce));
        last_cross_next = last_cross_reg;
        fire_time_next  = fire_time_reg;
        armed_mid       = armed_reg;
        pulse_mid       = pulse_reg;
        hit             = armed_reg && (fire_time_reg == tick_count_reg);
        if (accepted)
        begin
            last_cross_next = tick_count_reg;
            if (item.pct_zero)
            begin
                pulse_mid = '0;
                armed_mid = 1'b0;
                hit       = 1'b0;
            end
            else if (item.pct_full)
            begin
                pulse_mid = gate_pulse;
                armed_mid = 1'b0;
                hit       = 1'b0;
            end
            else
            begin
                fire_time_next = tick_count_reg + TICK_W'(item.delay);
                armed_mid      = 1'b1;
                hit            = (item.delay == '0);   // zero delay fires now
            end
        end
        armed_next = armed_mid;
        if (hit)
        begin
            armed_next = 1'b0;
            pulse_mid  = gate_pulse;
        end
        gate       = (pulse_mid != '0);
        pulse_next = gate ? pulse_mid - 1'b1 : pulse_mid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
            last_cross_reg <= '0;
            fire_time_reg  <= '0;
            armed_reg      <= 1'b0;
            pulse_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (item_ready)
                out_valid_reg <= item_valid;
            if (load)
            begin
                tick_count_reg <= tick_count_reg + 1'b1;
                last_cross_reg <= last_cross_next;
                fire_time_reg  <= fire_time_next;
                armed_reg      <= armed_next;
                pulse_reg      <= pulse_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            gate_level_reg  <= gate;
            zc_accepted_reg <= accepted;
        end
    end

    assign out_valid   = out_valid_reg;
    assign gate_level  = gate_level_reg;
    assign zc_accepted = zc_accepted_reg;

endmodule

// ===== hdl/phase_angle_triac_dimmer_core.sv =====
// Top level of the phase-angle triac dimmer: configuration registers, delay pipe, phase unit.
// Depends on ptd_pkg, ptd_delay and ptd_phase.
`timescale 1ns / 1ps

// Phase-angle triac dimmer core.
// Input channel (in_valid / in_stall): one request per microsecond tick, carrying
// zc_rise (zero-cross rising edge this tick) and power_percent (0 off, >= 100 full).
// Output channel (out_valid / out_stall): one result per request, in order:
// gate_level (triac gate drive this tick) and zc_accepted (edge passed debounce).
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 half cycle, 1 gate pulse width, 2 zero-cross debounce; index 3 is ignored).
// Write only when no request is in flight.
// Path: a request passes four registers on its way from accept to result valid
// (input register, product, divide by 100 with clamp, then the tick state
// update into the result register). Throughput: one request per cycle while
// out_stall is low; the tick state loop (debounce compare, alarm compare, pulse
// counter) is combinational between the tick state registers.
// Reset: tick counter, timestamps, alarm and pulse clear; config regs take
// their defaults (10000, 100, 2000). The block accepts requests right away.
// Stall: a stalled result holds in the result register; the pipe keeps
// filling until each of its four stages is full, then in_stall rises.
module phase_angle_triac_dimmer_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        zc_rise,
    input  logic [ptd_pkg::PCT_W-1:0]   power_percent,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic                        gate_level,
    output logic                        zc_accepted,
    input  logic                        cfg_we,
    input  logic [1:0]                  cfg_index,
    input  logic [ptd_pkg::CFG_W-1:0]   cfg_data
);
    import ptd_pkg::*;

    logic [HALF_W-1:0]  half_cycle_reg;
    logic [PULSE_W-1:0] gate_pulse_reg;
    logic [DEB_W-1:0]   zc_debounce_reg;
    logic [HALF_W-1:0]  delay_limit;
    logic               in_ready;
    logic               item_valid, item_ready;
    ptd_item_t          item;
    logic [2:0]         inflight_reg, inflight_next;
    logic               in_acc, out_acc;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_cycle_reg  <= HALF_RST;
            gate_pulse_reg  <= PULSE_RST;
            zc_debounce_reg <= DEB_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_HALF_CYCLE:  half_cycle_reg  <= cfg_data;
                CFG_GATE_PULSE:  gate_pulse_reg  <= cfg_data[PULSE_W-1:0];
                CFG_ZC_DEBOUNCE: zc_debounce_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // latest alarm delay: half_cycle - pulse - 1, or 0 when not positive
    always_comb
    begin
        if ({1'b0, half_cycle_reg} > ({5'd0, gate_pulse_reg} + 17'd1))
            delay_limit = half_cycle_reg - {4'd0, gate_pulse_reg} - 16'd1;
        else
            delay_limit = '0;
    end

    ptd_delay u_delay (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rise        (zc_rise),
        .pct         (power_percent),
        .half_cycle  (half_cycle_reg),
        .delay_limit (delay_limit),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item)
    );

    ptd_phase u_phase (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .gate_pulse  (gate_pulse_reg),
        .zc_debounce (zc_debounce_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .gate_level  (gate_level),
        .zc_accepted (zc_accepted)
    );

    assign in_stall = !in_ready;

    // requests in flight, for the checks below
    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_acc && !out_acc)
            inflight_next = inflight_reg + 3'd1;
        else if (out_acc && !in_acc)
            inflight_next = inflight_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    // an empty result register never backs up the input
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty result register");

    // at most one request per pipe stage
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= 3'd4)
        else $error("more requests in flight than pipe stages");

    // a result is only shown for a request that was taken
    a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != 3'd0)
        else $error("result without a pending request");

    // a full pipe with a stalled result stalls the input
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (inflight_reg == 3'd4) && out_stall |-> in_stall)
        else $error("request accepted into a full pipe");

endmodule
